// ===== src/multi_cue_temporal_vote_detector_top_defines.svh =====
// assertion macros for the vote detector checker
`ifndef MULTI_CUE_TEMPORAL_VOTE_DETECTOR_TOP_DEFINES_SVH
`define MULTI_CUE_TEMPORAL_VOTE_DETECTOR_TOP_DEFINES_SVH
// implication checked every clock outside reset
`define MCTVD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mctvd check failed");
// next-cycle implication
`define MCTVD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mctvd check failed");
`endif

// ===== src/mctvd_pkg.sv =====
// shared types and constants of the vote detector
package mctvd_pkg;
  localparam logic [1:0] VERDICT_UNKNOWN   = 2'd0;
  localparam logic [1:0] VERDICT_NONE      = 2'd1;
  localparam logic [1:0] VERDICT_POSSIBLE  = 2'd2;
  localparam logic [1:0] VERDICT_CONFIRMED = 2'd3;
  localparam int unsigned REG_CLASS_ENABLED = 0;
  localparam int unsigned REG_NEAR_FRACTION = 1;
  localparam int unsigned REG_WINDOW_MS     = 2;
  localparam int unsigned MIN_HITS          = 3;
endpackage

// ===== src/multi_cue_temporal_vote_detector_top.sv =====
// Multi-cue temporal vote detector. Hand-box beats (cmd 0) set a near flag when the hand
// centre lies within near_fraction/256 * face_width of the mouth; a frame beat (cmd 1)
// forms the cue, pushes it with its timestamp into a history ring kept in one synchronous
// memory, prunes entries older than window_ms from the oldest end and votes a verdict.
// Distances are squared and compared in half pixels on one shared multiplier, one product
// a cycle. A hand beat keeps in_stall high after it is taken through the two squares, the
// threshold and the compare. A frame beat keeps it high through those, the push and, per
// pruned entry and for the first one kept, a registered memory read of the oldest
// timestamp and its check; its verdict enters the output register at the end of the last
// of them. A frame that is unavailable or whose class is disabled gets an unknown verdict
// after the compare. There is no clearing pass after reset. The result sits in an output
// register of its own, so hand beats go on while a verdict waits; a frame whose verdict is
// ready waits in its last state, input stalled, until the previous verdict is taken.
module multi_cue_temporal_vote_detector_top
  import mctvd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 64,
  parameter int COORD_BITS    = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [COORD_BITS-1:0] box_x,
  input  logic [COORD_BITS-1:0] box_y,
  input  logic [COORD_BITS-1:0] box_w,
  input  logic [COORD_BITS-1:0] box_h,
  input  logic [COORD_BITS-1:0] mouth_x,
  input  logic [COORD_BITS-1:0] mouth_y,
  input  logic [COORD_BITS-1:0] face_width,
  input  logic                  obj_available,
  input  logic                  obj_present,
  input  logic [7:0]            obj_confidence,
  input  logic [31:0]           time_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  valid_result,
  output logic [1:0]            verdict,
  output logic [7:0]            verdict_confidence,
  output logic [11:0]           out_x,
  output logic [11:0]           out_y,
  output logic [11:0]           out_w,
  output logic [11:0]           out_h
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int DW = COORD_BITS + 2;          // magnitude of a half-pixel delta
  localparam int TW = COORD_BITS + 13;         // 2*nf*fw
  localparam int SW = 2 * TW;                  // squares
  localparam int MW = (DW > TW) ? DW : TW;     // multiplier operand

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_THR, S_CMP, S_PUSH, S_PRD, S_PCHK, S_VOTE
  } state_t;

  state_t state;

  // configuration
  logic        class_enabled;
  logic [11:0] near_fraction;
  logic [15:0] window_ms;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_enabled <= 1'b1;
      near_fraction <= 12'd128;
      window_ms     <= 16'd1500;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        2'(REG_CLASS_ENABLED): class_enabled <= pwdata[0];
        2'(REG_NEAR_FRACTION): near_fraction <= pwdata[11:0];
        2'(REG_WINDOW_MS):     window_ms     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      2'(REG_CLASS_ENABLED): prdata = {31'd0, class_enabled};
      2'(REG_NEAR_FRACTION): prdata = {20'd0, near_fraction};
      2'(REG_WINDOW_MS):     prdata = {16'd0, window_ms};
      default:               prdata = 32'd0;
    endcase
  end

  // history memory: timestamp and cue bit per entry
  logic [32:0] hist_mem [HISTORY_DEPTH];
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [32:0] mem_wdata, mem_rdata;
  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= hist_mem[mem_raddr];
  end

  // captured beat
  logic                  c_cmd, c_avail, c_present;
  logic [COORD_BITS-1:0] c_x, c_y, c_w, c_h, c_fw;
  logic [7:0]            c_conf;
  logic [31:0]           c_time;
  logic [DW-1:0]         adx, ady;

  // ring control
  logic [AW-1:0] oldest_index;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] hit_total;
  logic          hand_near_flag;
  logic          cue;

  // shared multiplier
  logic [MW-1:0] mul_a;
  logic [SW-1:0] mul_p, sum_sq;
  logic [TW-1:0] thr;
  always_comb begin
    case (state)
      S_SQX:   mul_a = MW'(adx);
      S_SQY:   mul_a = MW'(ady);
      default: mul_a = MW'(thr);
    endcase
  end

  // half-pixel deltas of the box centre from the mouth
  logic signed [DW:0] dx_s, dy_s;
  assign dx_s = $signed({2'b00, box_x, 1'b0}) + $signed((DW+1)'(box_w))
              - $signed({2'b00, mouth_x, 1'b0});
  assign dy_s = $signed({2'b00, box_y, 1'b0}) + $signed((DW+1)'(box_h))
              - $signed({2'b00, mouth_y, 1'b0});

  logic          is_near;
  logic [CW:0]   slot_sum;
  logic [AW-1:0] push_slot;
  logic [AW-1:0] oldest_inc;
  logic [31:0]   age;
  logic          ring_full;
  logic [CW:0]   hit2;
  logic          out_free;
  logic          res_load;
  assign is_near    = ({sum_sq[SW-17:0], 16'd0} < mul_p);
  assign ring_full  = (entry_count == CW'(HISTORY_DEPTH));
  // ring indexes wrap at the depth, which need not be a power of two
  assign slot_sum   = (CW+1)'(oldest_index) + (CW+1)'(entry_count);
  assign push_slot  = (slot_sum >= (CW+1)'(HISTORY_DEPTH)) ?
                      AW'(slot_sum - (CW+1)'(HISTORY_DEPTH)) : AW'(slot_sum);
  assign oldest_inc = (oldest_index == AW'(HISTORY_DEPTH - 1)) ? '0 : oldest_index + 1'b1;
  assign age        = c_time - mem_rdata[31:0];
  assign hit2       = {hit_total, 1'b0};

  // output register can take a new verdict when empty or being drained
  assign out_free = !out_valid || !out_stall;
  assign res_load = out_free && ((state == S_VOTE) ||
                    (state == S_CMP && c_cmd && (!class_enabled || !c_avail)));

  assign in_stall = (state != S_IDLE);

  always_comb begin
    mem_we    = (state == S_PUSH);
    mem_waddr = ring_full ? oldest_index : push_slot;
    mem_wdata = {cue, c_time};
    mem_raddr = oldest_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      oldest_index   <= '0;
      entry_count    <= '0;
      hit_total      <= '0;
      hand_near_flag <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_cmd <= cmd; c_avail <= obj_available; c_present <= obj_present;
            c_x <= box_x; c_y <= box_y; c_w <= box_w; c_h <= box_h;
            c_fw <= face_width; c_conf <= obj_confidence; c_time <= time_ms;
            adx <= DW'(dx_s[DW] ? -dx_s : dx_s);
            ady <= DW'(dy_s[DW] ? -dy_s : dy_s);
            thr <= TW'({near_fraction, 1'b0}) * TW'(face_width);
            state <= S_SQX;
          end
        end
        S_SQX: begin
          mul_p <= SW'(mul_a) * SW'(mul_a);
          state <= S_SQY;
        end
        S_SQY: begin
          sum_sq <= mul_p;
          mul_p  <= SW'(mul_a) * SW'(mul_a);
          state  <= S_THR;
        end
        S_THR: begin
          sum_sq <= sum_sq + mul_p;
          mul_p  <= SW'(mul_a) * SW'(mul_a);
          state  <= S_CMP;
        end
        S_CMP: begin
          if (!c_cmd) begin
            if (is_near) hand_near_flag <= 1'b1;
            state <= S_IDLE;
          end else begin
            hand_near_flag <= 1'b0;
            if (!class_enabled || !c_avail) begin
              // unknown verdict, held here until the output register is free
              if (out_free) begin
                valid_result <= 1'b0; verdict <= VERDICT_UNKNOWN;
                verdict_confidence <= 8'd0;
                out_x <= '0; out_y <= '0; out_w <= '0; out_h <= '0;
                state <= S_IDLE;
              end
            end else begin
              cue <= c_present && (c_fw >= COORD_BITS'(2)) && hand_near_flag && is_near;
              state <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          // a full ring overwrites its oldest entry
          if (ring_full) begin
            hit_total    <= hit_total - CW'(mem_rdata[32]) + CW'(cue);
            oldest_index <= oldest_inc;
          end else begin
            hit_total   <= hit_total + CW'(cue);
            entry_count <= entry_count + 1'b1;
          end
          state <= S_PRD;
        end
        S_PRD: state <= S_PCHK;   // memory read of the oldest entry
        S_PCHK: begin
          if (age > 32'(window_ms)) begin
            hit_total    <= hit_total - CW'(mem_rdata[32]);
            oldest_index <= oldest_inc;
            entry_count  <= entry_count - 1'b1;
            state        <= S_PRD;
          end else begin
            state <= S_VOTE;
          end
        end
        S_VOTE: begin
          if (out_free) begin
            valid_result <= 1'b1;
            if (hit_total >= CW'(MIN_HITS) && hit2 >= (CW+1)'(entry_count)) begin
              verdict <= VERDICT_CONFIRMED; verdict_confidence <= c_conf;
            end else if (cue) begin
              verdict <= VERDICT_POSSIBLE; verdict_confidence <= {1'b0, c_conf[7:1]};
            end else begin
              verdict <= VERDICT_NONE; verdict_confidence <= 8'd0;
            end
            out_x <= 12'(c_x); out_y <= 12'(c_y); out_w <= 12'(c_w); out_h <= 12'(c_h);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule

// ===== src/mctvd_checker.sv =====
// port-level checker for the vote detector, bound to the top level
`include "multi_cue_temporal_vote_detector_top_defines.svh"
module mctvd_checker
  import mctvd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       valid_result,
  input logic [1:0] verdict,
  input logic [7:0] verdict_confidence
);
  logic low_verdict;
  assign low_verdict = (verdict == VERDICT_NONE) || (verdict == VERDICT_UNKNOWN);

  `MCTVD_ASSERT_IMP(a_unknown_iff_invalid, out_valid, (verdict == VERDICT_UNKNOWN) == !valid_result)
  `MCTVD_ASSERT_IMP(a_none_zero_conf, out_valid && low_verdict, verdict_confidence == 8'd0)
  `MCTVD_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
  `MCTVD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(verdict))
endmodule

bind multi_cue_temporal_vote_detector_top mctvd_checker u_mctvd_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .valid_result(valid_result),
  .verdict(verdict), .verdict_confidence(verdict_confidence)
);
